// ===== rtl/lsc_pkg.sv =====
// Shared types, constants and helpers for the line segment clipper.
package lsc_pkg;

	// coordinate, difference and product widths
	localparam int CW = 16;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int MAX_PASSES = 8;
	localparam int MW = $clog2(MAX_PASSES + 1);

	// region code bits
	localparam logic [3:0] CODE_ABOVE = 4'd8;
	localparam logic [3:0] CODE_BELOW = 4'd4;
	localparam logic [3:0] CODE_RIGHT = 4'd2;
	localparam logic [3:0] CODE_LEFT  = 4'd1;

	// configuration register indexes
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_TOP    = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_BOTTOM = 2'd3;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;

	// one beat between neighbouring divider cells
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [DW-1:0] dvd;
		logic [DW-1:0] quo;
	} div_bus_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CODE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [3:0] region(input coord_t x, input coord_t y,
		input coord_t wl, input coord_t wt, input coord_t wr, input coord_t wb);
		logic [3:0] c;
		c = '0;
		if (y < wt) c = c | CODE_ABOVE;
		if (y > wb) c = c | CODE_BELOW;
		if (x > wr) c = c | CODE_RIGHT;
		if (x < wl) c = c | CODE_LEFT;
		return c;
	endfunction

	function automatic logic [DW-1:0] mag(input diff_t v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	function automatic diff_t sx(input coord_t c);
		return {c[CW-1], c};
	endfunction

endpackage

// ===== rtl/lsc_div_cell.sv =====
// One restoring division cell: yields one quotient bit per beat.
module lsc_div_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  lsc_pkg::div_bus_t          in_bus,
	input  logic [lsc_pkg::DW-1:0]     den,
	output logic                       out_valid,
	output lsc_pkg::div_bus_t          out_bus
);
	logic [lsc_pkg::DW:0]   trial;
	logic [lsc_pkg::DW:0]   diff;
	logic                   ge;
	lsc_pkg::div_bus_t      nxt;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial   = {in_bus.rem, in_bus.dvd[lsc_pkg::DW-1]};
		diff    = trial - {1'b0, den};
		ge      = trial >= {1'b0, den};
		nxt.rem = ge ? diff[lsc_pkg::DW-1:0] : trial[lsc_pkg::DW-1:0];
		nxt.dvd = {in_bus.dvd[lsc_pkg::DW-2:0], 1'b0};
		nxt.quo = {in_bus.quo[lsc_pkg::DW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_bus <= nxt;
	end
endmodule

// ===== rtl/lsc_divider.sv =====
// Row of division cells: product over divisor, one quotient bit per cell.
module lsc_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lsc_pkg::PW-1:0]     prod,
	input  logic [lsc_pkg::DW-1:0]     den,
	output logic                       done,
	output logic [lsc_pkg::DW-1:0]     quo,
	output logic                       rem_nz
);
	lsc_pkg::div_bus_t          bus [lsc_pkg::DW+1];
	logic [lsc_pkg::DW:0]       vld;

	// high half of the product is already below the divisor
	assign bus[0].rem = prod[lsc_pkg::PW-1:lsc_pkg::DW];
	assign bus[0].dvd = prod[lsc_pkg::DW-1:0];
	assign bus[0].quo = '0;
	assign vld[0]     = start;

	for (genvar i = 0; i < lsc_pkg::DW; i++) begin : g_cell
		lsc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_bus    (bus[i]),
			.den       (den),
			.out_valid (vld[i+1]),
			.out_bus   (bus[i+1])
		);
	end

	assign done   = vld[lsc_pkg::DW];
	assign quo    = bus[lsc_pkg::DW].quo;
	assign rem_nz = bus[lsc_pkg::DW].rem != '0;
endmodule

// ===== rtl/line_segment_clipper.sv =====
// Top level: Cohen-Sutherland segment clipper with a cell-chain divider.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid/tready     tdata: start_x, start_y, end_x, end_y
//  m_*      out  tvalid/tready     tdata: clipped coords; tuser: visible, limit
//  cfg_*    in   cfg_we            cfg_index selects window register
//
// A segment makes at most MAX_PASSES endpoint moves, each through the code,
// multiply and divide states; each runs the product through the 17-cell
// divider row. One segment is in work at a time. A finished beat sits in the
// output register, so the next segment is taken while it waits. Reset loads
// the default 640x480 window and empties the block.
module line_segment_clipper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // clipped_start_x, _y, clipped_end_x, _y
	output logic [1:0]  m_tuser,   // visible, pass_limit_hit
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CW = lsc_pkg::CW;
	localparam int DW = lsc_pkg::DW;

	lsc_pkg::state_t state_q, state_n;
	lsc_pkg::coord_t wl_q, wt_q, wr_q, wb_q;
	lsc_pkg::coord_t x1_q, y1_q, x2_q, y2_q;
	lsc_pkg::coord_t base_q, nc_q;
	logic [DW-1:0]   dmag_q, nmag_q, den_q;
	logic            neg_q, side_q, axis_x_q;
	logic [lsc_pkg::PW-1:0] prod_q;
	logic [lsc_pkg::MW-1:0] moves_q;
	logic            vis_q, lim_q, start_q;
	logic            out_vld_q, out_vis_q, out_lim_q;
	logic [63:0]     out_data_q;

	logic [3:0]      c1, c2, oc;
	logic            setup, finish, decide, dec_vis, dec_lim, load_out;
	lsc_pkg::diff_t  sd, snum, sden;
	lsc_pkg::coord_t sbase, snc;
	logic            saxis_x;
	logic            div_done, rem_nz;
	logic [DW-1:0]   quo;
	logic [DW:0]     base_w, sum_w, adj_w;
	logic            negv;
	lsc_pkg::coord_t newc;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= 16'sd0;
			wt_q <= 16'sd0;
			wr_q <= 16'sd639;
			wb_q <= 16'sd479;
		end else if (cfg_we) begin
			case (cfg_index)
				lsc_pkg::REG_LEFT:   wl_q <= cfg_data;
				lsc_pkg::REG_TOP:    wt_q <= cfg_data;
				lsc_pkg::REG_RIGHT:  wr_q <= cfg_data;
				lsc_pkg::REG_BOTTOM: wb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// region codes and the next edge to clip against
	always_comb begin
		c1 = lsc_pkg::region(x1_q, y1_q, wl_q, wt_q, wr_q, wb_q);
		c2 = lsc_pkg::region(x2_q, y2_q, wl_q, wt_q, wr_q, wb_q);
		oc = (c1 != '0) ? c1 : c2;
		if ((oc & lsc_pkg::CODE_ABOVE) != '0) begin
			snc = wt_q; sbase = x1_q; saxis_x = 1'b1;
			sd = lsc_pkg::sx(x2_q) - lsc_pkg::sx(x1_q);
			snum = lsc_pkg::sx(wt_q) - lsc_pkg::sx(y1_q);
			sden = lsc_pkg::sx(y2_q) - lsc_pkg::sx(y1_q);
		end else if ((oc & lsc_pkg::CODE_BELOW) != '0) begin
			snc = wb_q; sbase = x1_q; saxis_x = 1'b1;
			sd = lsc_pkg::sx(x2_q) - lsc_pkg::sx(x1_q);
			snum = lsc_pkg::sx(wb_q) - lsc_pkg::sx(y1_q);
			sden = lsc_pkg::sx(y2_q) - lsc_pkg::sx(y1_q);
		end else if ((oc & lsc_pkg::CODE_RIGHT) != '0) begin
			snc = wr_q; sbase = y1_q; saxis_x = 1'b0;
			sd = lsc_pkg::sx(y2_q) - lsc_pkg::sx(y1_q);
			snum = lsc_pkg::sx(wr_q) - lsc_pkg::sx(x1_q);
			sden = lsc_pkg::sx(x2_q) - lsc_pkg::sx(x1_q);
		end else begin
			snc = wl_q; sbase = y1_q; saxis_x = 1'b0;
			sd = lsc_pkg::sx(y2_q) - lsc_pkg::sx(y1_q);
			snum = lsc_pkg::sx(wl_q) - lsc_pkg::sx(x1_q);
			sden = lsc_pkg::sx(x2_q) - lsc_pkg::sx(x1_q);
		end
	end

	// truncate toward zero after the exact quotient
	always_comb begin
		negv   = neg_q & (prod_q != '0);
		base_w = {base_q[CW-1], base_q[CW-1], base_q};
		sum_w  = negv ? base_w - {1'b0, quo} : base_w + {1'b0, quo};
		adj_w  = sum_w;
		if (rem_nz) begin
			if (!negv && sum_w[DW]) adj_w = sum_w + 1'b1;
			if (negv && !sum_w[DW] && sum_w != '0) adj_w = sum_w - 1'b1;
		end
		newc = (den_q == '0) ? base_q : adj_w[CW-1:0];
	end

	// sequencer
	always_comb begin
		state_n  = state_q;
		s_tready = 1'b0;
		setup    = 1'b0;
		finish   = 1'b0;
		decide   = 1'b0;
		dec_vis  = 1'b0;
		dec_lim  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			lsc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_n = lsc_pkg::ST_CODE;
			end
			lsc_pkg::ST_CODE: begin
				if ((c1 | c2) == '0) begin
					decide = 1'b1; dec_vis = 1'b1;
				end else if ((c1 & c2) != '0) begin
					decide = 1'b1;
				end else if (moves_q == lsc_pkg::MW'(lsc_pkg::MAX_PASSES)) begin
					decide = 1'b1; dec_lim = 1'b1;
				end else begin
					setup = 1'b1;
				end
				state_n = decide ? lsc_pkg::ST_DONE : lsc_pkg::ST_MUL;
			end
			lsc_pkg::ST_MUL: state_n = lsc_pkg::ST_DIV;
			lsc_pkg::ST_DIV: begin
				if (div_done) begin
					finish  = 1'b1;
					state_n = lsc_pkg::ST_CODE;
				end
			end
			lsc_pkg::ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					load_out = 1'b1;
					state_n  = lsc_pkg::ST_IDLE;
				end
			end
			default: state_n = lsc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lsc_pkg::ST_IDLE;
			moves_q   <= '0;
			start_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			start_q <= state_q == lsc_pkg::ST_MUL;
			if (s_tvalid && s_tready) moves_q <= '0;
			else if (finish) moves_q <= moves_q + 1'b1;
			if (load_out) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// endpoint and pass operand registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x1_q <= s_tdata[15:0];
			y1_q <= s_tdata[31:16];
			x2_q <= s_tdata[47:32];
			y2_q <= s_tdata[63:48];
		end else if (finish) begin
			if (side_q) begin
				x2_q <= axis_x_q ? newc : nc_q;
				y2_q <= axis_x_q ? nc_q : newc;
			end else begin
				x1_q <= axis_x_q ? newc : nc_q;
				y1_q <= axis_x_q ? nc_q : newc;
			end
		end
		if (setup) begin
			base_q   <= sbase;
			nc_q     <= snc;
			axis_x_q <= saxis_x;
			side_q   <= c1 == '0;
			dmag_q   <= lsc_pkg::mag(sd);
			nmag_q   <= lsc_pkg::mag(snum);
			den_q    <= lsc_pkg::mag(sden);
			neg_q    <= sd[DW-1] ^ snum[DW-1] ^ sden[DW-1];
		end
		if (state_q == lsc_pkg::ST_MUL) prod_q <= dmag_q * nmag_q;
		if (decide) begin
			vis_q <= dec_vis;
			lim_q <= dec_lim;
		end
		if (load_out) begin
			out_vis_q  <= vis_q;
			out_lim_q  <= lim_q;
			out_data_q <= vis_q ? {y2_q, x2_q, y1_q, x1_q} : '0;
		end
	end

	lsc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.prod   (prod_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo),
		.rem_nz (rem_nz)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_lim_q, out_vis_q};

	// move count never passes the bound
	a_moves: assert property (@(posedge clk) disable iff (!arst_n)
		moves_q <= lsc_pkg::MW'(lsc_pkg::MAX_PASSES))
		else $error("move count beyond bound");
	// divider answers only while a pass waits for it
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == lsc_pkg::ST_DIV)
		else $error("stray divider result");
	// visible and pass limit exclude each other
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("visible with pass limit");
	// a rejected segment carries zero coordinates
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tdata == '0)
		else $error("rejected beat not zero");
	// a pass starts the divider in the cycle after the multiply state
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lsc_pkg::ST_MUL |=> start_q)
		else $error("divider not started");
endmodule

// ===== tb/line_segment_clipper_tb.sv =====
// Testbench for the line segment clipper: directed table, special windows, then random segments
`timescale 1ns / 100ps

module line_segment_clipper_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 400;

	typedef struct packed {
		logic        visible;
		logic        limit_hit;
		logic [15:0] sx0;
		logic [15:0] sy0;
		logic [15:0] ex0;
		logic [15:0] ey0;
	} clip_res_t;

	typedef struct {
		logic [15:0] x1, y1, x2, y2;
		bit          has_res;
		clip_res_t   res;
	} seg_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = lsc_pkg::REG_LEFT;
	logic [15:0] cfg_data = '0;

	// window copy used by the predictor
	longint win_l, win_t, win_r, win_b;

	clip_res_t clip_q[$];
	int        n_err = 0;
	int        idle_cnt = 0;
	bit        rx_stall_en = 1'b1;

	line_segment_clipper i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint sext16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [3:0] outcode(longint x, longint y);
		logic [3:0] c;
		c = '0;
		if (y < win_t) c |= lsc_pkg::CODE_ABOVE;
		if (y > win_b) c |= lsc_pkg::CODE_BELOW;
		if (x > win_r) c |= lsc_pkg::CODE_RIGHT;
		if (x < win_l) c |= lsc_pkg::CODE_LEFT;
		return c;
	endfunction

	// c1 + d*num/den as one rational, truncated toward zero
	function automatic longint edge_cross(longint c1, longint d, longint num, longint den);
		longint p, q, r, b;
		bit     neg;
		if (den == 0) return c1;
		p = (d < 0 ? -d : d) * (num < 0 ? -num : num);
		q = p / (den < 0 ? -den : den);
		r = p % (den < 0 ? -den : den);
		neg = ((d < 0) != (num < 0)) != (den < 0);
		if (p == 0) neg = 1'b0;
		b = neg ? c1 - q : c1 + q;
		if (r == 0) return b;
		if (!neg) return b >= 0 ? b : b + 1;
		return b > 0 ? b - 1 : b;
	endfunction

	function automatic clip_res_t clip_segment(logic [15:0] ax, logic [15:0] ay,
		logic [15:0] bx, logic [15:0] by);
		longint    x1, y1, x2, y2, nx, ny;
		logic [3:0] c1, c2, oc;
		int        moves;
		int        verdict;
		clip_res_t r;
		x1 = sext16(ax); y1 = sext16(ay); x2 = sext16(bx); y2 = sext16(by);
		moves = 0;
		verdict = 0;
		while (verdict == 0) begin
			c1 = outcode(x1, y1);
			c2 = outcode(x2, y2);
			if ((c1 | c2) == 0) verdict = 1;
			else if ((c1 & c2) != 0) verdict = 2;
			else if (moves >= lsc_pkg::MAX_PASSES) verdict = 3;
			else begin
				oc = (c1 != 0) ? c1 : c2;
				if (oc & lsc_pkg::CODE_ABOVE) begin
					ny = win_t; nx = edge_cross(x1, x2 - x1, win_t - y1, y2 - y1);
				end else if (oc & lsc_pkg::CODE_BELOW) begin
					ny = win_b; nx = edge_cross(x1, x2 - x1, win_b - y1, y2 - y1);
				end else if (oc & lsc_pkg::CODE_RIGHT) begin
					nx = win_r; ny = edge_cross(y1, y2 - y1, win_r - x1, x2 - x1);
				end else begin
					nx = win_l; ny = edge_cross(y1, y2 - y1, win_l - x1, x2 - x1);
				end
				if (c1 != 0) begin x1 = nx; y1 = ny; end
				else begin x2 = nx; y2 = ny; end
				moves++;
			end
		end
		r = '0;
		if (verdict == 1) begin
			r.visible = 1'b1;
			r.sx0 = x1[15:0]; r.sy0 = y1[15:0]; r.ex0 = x2[15:0]; r.ey0 = y2[15:0];
		end
		r.limit_hit = (verdict == 3);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		n_err++;
	endtask

	// random gap: mostly short, sometimes long
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic write_window(logic [15:0] l, logic [15:0] t, logic [15:0] r,
		logic [15:0] b);
		logic [15:0] vals [4];
		vals = '{l, t, r, b};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		win_l = sext16(l); win_t = sext16(t); win_r = sext16(r); win_b = sext16(b);
	endtask

	// one beat in; valid drops for a cycle after each accept
	task automatic send_segment(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
		logic [15:0] y2, bit has_res, clip_res_t want);
		clip_q.push_back(has_res ? want : clip_segment(x1, y1, x2, y2));
		s_tvalid <= 1'b1;
		s_tdata <= {y2, x2, y1, x1};
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_gapped(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
		logic [15:0] y2);
		int g;
		g = gap_len();
		wait_cycles(g);
		send_segment(x1, y1, x2, y2, 1'b0, '0);
	endtask

	task automatic drain();
		while (clip_q.size() != 0) @(posedge clk);
		wait_cycles(DRAIN_CYCLES / 2);
	endtask

	function automatic logic [15:0] rnd_coord(int spread);
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 16'($urandom());
		if (k == 1) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		return 16'($signed($urandom_range(0, 2 * spread)) - spread + 200);
	endfunction

	// receiver with random back-pressure unless stalls are disabled; checks each beat
	always @(posedge clk) begin
		clip_res_t w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (clip_q.size() == 0) begin
					$display("unexpected result beat at %0t", $realtime);
					n_err++;
				end else begin
					w = clip_q.pop_front();
					if (m_tuser[0] !== w.visible)
						report_mismatch("visible", 16'(m_tuser[0]), 16'(w.visible));
					if (m_tuser[1] !== w.limit_hit)
						report_mismatch("pass_limit_hit", 16'(m_tuser[1]),
							16'(w.limit_hit));
					if (m_tdata[15:0] !== w.sx0)
						report_mismatch("clipped_start_x", m_tdata[15:0], w.sx0);
					if (m_tdata[31:16] !== w.sy0)
						report_mismatch("clipped_start_y", m_tdata[31:16], w.sy0);
					if (m_tdata[47:32] !== w.ex0)
						report_mismatch("clipped_end_x", m_tdata[47:32], w.ex0);
					if (m_tdata[63:48] !== w.ey0)
						report_mismatch("clipped_end_y", m_tdata[63:48], w.ey0);
				end
			end
			m_tready <= !rx_stall_en || (gap_len() == 0);
		end
	end

	// watchdog on cycles with no beat either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		seg_row_t rows[$];
		clip_res_t rej, in_full;
		int n_sets;
		rej = '0;
		win_l = 0; win_t = 0; win_r = 639; win_b = 479;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset window, extremes, rejects, one edge per code
		in_full = '{1'b1, 1'b0, 16'd10, 16'd20, 16'd300, 16'd400};
		rows.push_back('{16'd10, 16'd20, 16'd300, 16'd400, 1'b1, in_full});
		in_full = '{1'b1, 1'b0, 16'd0, 16'd0, 16'd639, 16'd479};
		rows.push_back('{16'd0, 16'd0, 16'd639, 16'd479, 1'b1, in_full});
		rows.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1'b1, rej});
		rows.push_back('{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 1'b1, rej});
		rows.push_back('{16'h8000, 16'h8000, 16'h7fff, 16'h8000, 1'b1, rej});
		rows.push_back('{16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, rej});
		rows.push_back('{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, rej});
		rows.push_back('{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0, rej});
		rows.push_back('{16'd100, 16'hffce, 16'd200, 16'd100, 1'b0, rej});
		rows.push_back('{16'd100, 16'd600, 16'd200, 16'd100, 1'b0, rej});
		rows.push_back('{16'd700, 16'd100, 16'd300, 16'd200, 1'b0, rej});
		rows.push_back('{16'hff9c, 16'd100, 16'd300, 16'd200, 1'b0, rej});
		rows.push_back('{16'd300, 16'd200, 16'hff9c, 16'd700, 1'b0, rej});
		rows.push_back('{16'hfff6, 16'd470, 16'd20, 16'd490, 1'b0, rej});
		rows.push_back('{16'hffff, 16'd5, 16'd7, 16'hffff, 1'b0, rej});
		rows.push_back('{16'hffff, 16'hffff, 16'd640, 16'd480, 1'b0, rej});
		foreach (rows[i]) begin
			wait_cycles(gap_len());
			send_segment(rows[i].x1, rows[i].y1, rows[i].x2, rows[i].y2,
				rows[i].has_res, rows[i].res);
		end
		drain();

		// inverted window and a degenerate one-point window
		write_window(16'd500, 16'd400, 16'd100, 16'd50);
		send_gapped(16'd300, 16'd200, 16'd300, 16'd200);
		send_gapped(16'd0, 16'd0, 16'd600, 16'd500);
		drain();
		write_window(16'd5, 16'd5, 16'd5, 16'd5);
		send_gapped(16'd0, 16'd0, 16'd10, 16'd10);
		send_gapped(16'd5, 16'd5, 16'd5, 16'd5);
		send_gapped(16'd0, 16'd1, 16'd10, 16'd11);
		drain();

		// random phases over a range of windows, extremes included
		n_sets = 10;
		for (int s = 0; s < n_sets; s++) begin
			logic [15:0] l, t, r, b;
			int spread;
			case (s)
				0: begin l = 16'h8000; t = 16'h8000; r = 16'h7fff; b = 16'h7fff; end
				1: begin l = 16'h7fff; t = 16'h7fff; r = 16'h8000; b = 16'h8000; end
				2: begin l = 16'hffff; t = 16'h0000; r = 16'h0001; b = 16'hffff; end
				default: begin
					l = 16'($signed($urandom_range(0, 600)) - 300);
					t = 16'($signed($urandom_range(0, 600)) - 300);
					r = 16'(l + $urandom_range(0, 800));
					b = 16'(t + $urandom_range(0, 800));
				end
			endcase
			write_window(l, t, r, b);
			spread = (s < 3) ? 20000 : 1500;
			rx_stall_en = (s % 3) != 2;
			for (int i = 0; i < 95; i++)
				send_gapped(rnd_coord(spread), rnd_coord(spread),
					rnd_coord(spread), rnd_coord(spread));
			drain();
		end

		write_window(16'd0, 16'd0, 16'd639, 16'd479);
		drain();
		wait_cycles(DRAIN_CYCLES / 2);
		if (n_err == 0 && clip_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
